[hw/rtl/dtsfs_pkg.sv]
// ----------------------------------------------------------------------------
// dtsfs_pkg
// Shared types and constants of the DTS core frame synchronizer.
// ----------------------------------------------------------------------------
package dtsfs_pkg;

  // byte ring between the hunting front end and the frame output side
  localparam int RING_AW    = 6;
  localparam int RING_DEPTH = 1 << RING_AW;

  localparam int HDR_LEN    = 11;
  localparam int WIN_LEN    = HDR_LEN - 1;
  localparam int SIZE_W     = 15;
  localparam int CMDQ_DEPTH = 4;
  localparam int OUT_DEPTH  = 4;

  localparam logic [SIZE_W-1:0] MIN_FRAME_RESET = 15'd96;
  localparam logic [SIZE_W-1:0] MIN_FRAME_FLOOR = 15'(HDR_LEN + 1);

  // floor(x / 7) == (x * RECIP7) >> RECIP7_SHIFT for every 15-bit frame size used here
  localparam logic [SIZE_W-1:0] RECIP7       = 15'd18725;
  localparam int                RECIP7_SHIFT = 17;
  localparam int                QUOT_W       = 12;

  typedef logic [RING_AW:0]  ptr_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [1:0] {
    KIND_16BE = 2'd0,
    KIND_16LE = 2'd1,
    KIND_14BE = 2'd2,
    KIND_14LE = 2'd3
  } kind_t;

  // one recognised frame, handed from front to back
  typedef struct packed {
    ptr_t  start;
    kind_t kind;
    size_t size;
  } cmd_t;

  typedef struct packed {
    logic busy;
    ptr_t rd;
  } back_stat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    kind_t      kind;
  } result_t;

endpackage

[hw/rtl/dtsfs_ram.sv]
// ----------------------------------------------------------------------------
// dtsfs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtsfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dtsfs_front.sv]
// ----------------------------------------------------------------------------
// dtsfs_front
// Input side: writes every byte to the ring, hunts for sync in a 10-byte
// window and issues one request per recognised frame.
// ----------------------------------------------------------------------------
module dtsfs_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [7:0]             in_byte,
  output logic                   full,
  input  dtsfs_pkg::size_t       min_frame_bytes,
  input  dtsfs_pkg::back_stat_t  back_stat,
  input  logic                   cmd_full,
  output logic                   cmd_push,
  output dtsfs_pkg::cmd_t        cmd,
  output dtsfs_pkg::ptr_t        commit,
  output logic                   ram_we,
  output logic [dtsfs_pkg::RING_AW-1:0] ram_waddr,
  output logic [7:0]             ram_wdata
);

  localparam logic [7:0] SYNC_7F = 8'h7F;
  localparam logic [7:0] SYNC_FE = 8'hFE;
  localparam logic [7:0] SYNC_80 = 8'h80;
  localparam logic [7:0] SYNC_01 = 8'h01;
  localparam logic [7:0] SYNC_1F = 8'h1F;
  localparam logic [7:0] SYNC_FF = 8'hFF;
  localparam logic [7:0] SYNC_E8 = 8'hE8;
  localparam logic [7:0] SYNC_00 = 8'h00;

  localparam int WL = dtsfs_pkg::WIN_LEN;
  localparam int SW = dtsfs_pkg::SIZE_W;

  logic [7:0]             win      [WL];
  logic [7:0]             win_next [WL];
  logic [3:0]             fill;
  logic                   in_frame;
  dtsfs_pkg::size_t       bytes_left;
  dtsfs_pkg::ptr_t        wr;
  dtsfs_pkg::ptr_t        win_start;

  // candidate header info for the current window, computed from the next window and registered with it
  logic                   cand_hit;
  dtsfs_pkg::kind_t       cand_kind;
  dtsfs_pkg::size_t       cand_fsz;
  logic [dtsfs_pkg::QUOT_W-1:0] cand_q;

  logic                   hit_next;
  dtsfs_pkg::kind_t       kind_next;
  logic [13:0]            raw_next;
  dtsfs_pkg::size_t       fsz_next;
  logic [2*SW-1:0]        prod_next;

  logic                   accept;
  logic                   hunt_full;
  logic                   size_ok;
  logic                   detect;
  logic                   drop;
  dtsfs_pkg::size_t       sum14;
  dtsfs_pkg::size_t       size;
  dtsfs_pkg::ptr_t        base;
  dtsfs_pkg::ptr_t        used;

  assign base   = back_stat.busy ? back_stat.rd : win_start;
  assign used   = wr - base;
  assign full   = used[dtsfs_pkg::RING_AW] || cmd_full;
  assign accept = push && !full;

  assign sum14 = cand_fsz + SW'(cand_q) + SW'(1);
  assign size  = (cand_kind == dtsfs_pkg::KIND_14BE || cand_kind == dtsfs_pkg::KIND_14LE)
               ? {sum14[SW-1:1], 1'b0} : cand_fsz;

  assign size_ok   = cand_hit && (size >= min_frame_bytes) &&
                     (size >= dtsfs_pkg::MIN_FRAME_FLOOR);
  assign hunt_full = !in_frame && (fill == 4'(WL));
  assign detect    = accept && hunt_full && size_ok;
  assign drop      = accept && hunt_full && !size_ok;

  assign cmd_push   = detect;
  assign cmd.start  = win_start;
  assign cmd.kind   = cand_kind;
  assign cmd.size   = size;

  assign ram_we    = accept;
  assign ram_waddr = wr[dtsfs_pkg::RING_AW-1:0];
  assign ram_wdata = in_byte;

  always_comb begin
    win_next = win;
    if (accept && !in_frame) begin
      if (fill < 4'(WL)) begin
        win_next[fill] = in_byte;
      end else if (drop) begin
        for (int i = 0; i < WL - 1; i++) begin
          win_next[i] = win[i + 1];
        end
        win_next[WL-1] = in_byte;
      end
    end
  end

  // sync word and frame size field of the next window
  always_comb begin
    hit_next  = 1'b1;
    kind_next = dtsfs_pkg::KIND_16BE;
    priority if (win_next[0] == SYNC_7F && win_next[1] == SYNC_FE &&
                 win_next[2] == SYNC_80 && win_next[3] == SYNC_01) begin
      kind_next = dtsfs_pkg::KIND_16BE;
    end else if (win_next[0] == SYNC_FE && win_next[1] == SYNC_7F &&
                 win_next[2] == SYNC_01 && win_next[3] == SYNC_80) begin
      kind_next = dtsfs_pkg::KIND_16LE;
    end else if (win_next[0] == SYNC_1F && win_next[1] == SYNC_FF &&
                 win_next[2] == SYNC_E8 && win_next[3] == SYNC_00) begin
      kind_next = dtsfs_pkg::KIND_14BE;
    end else if (win_next[0] == SYNC_FF && win_next[1] == SYNC_1F &&
                 win_next[2] == SYNC_00 && win_next[3] == SYNC_E8) begin
      kind_next = dtsfs_pkg::KIND_14LE;
    end else begin
      hit_next = 1'b0;
    end

    unique case (kind_next)
      dtsfs_pkg::KIND_16BE: raw_next = {win_next[5][1:0], win_next[6], win_next[7][7:4]};
      dtsfs_pkg::KIND_16LE: raw_next = {win_next[4][1:0], win_next[7], win_next[6][7:4]};
      dtsfs_pkg::KIND_14BE: raw_next = {win_next[6][1:0], win_next[7], win_next[8][5:2]};
      dtsfs_pkg::KIND_14LE: raw_next = {win_next[7][1:0], win_next[6], win_next[9][5:2]};
      default:              raw_next = '0;
    endcase

    fsz_next  = SW'(raw_next) + SW'(1);
    prod_next = (2*SW)'(fsz_next) * (2*SW)'(dtsfs_pkg::RECIP7);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win       <= win_next;
      cand_hit  <= hit_next;
      cand_kind <= kind_next;
      cand_fsz  <= fsz_next;
      cand_q    <= prod_next[dtsfs_pkg::RECIP7_SHIFT +: dtsfs_pkg::QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      in_frame   <= 1'b0;
      bytes_left <= '0;
      wr         <= '0;
      win_start  <= '0;
      commit     <= '0;
    end else if (accept) begin
      wr <= wr + 1'b1;
      if (in_frame) begin
        bytes_left <= bytes_left - 1'b1;
        if (bytes_left == SW'(1)) begin
          in_frame <= 1'b0;
        end
        commit    <= wr + 1'b1;
        win_start <= wr + 1'b1;
      end else if (detect) begin
        // the whole header, this byte included, becomes visible to the back end
        in_frame   <= 1'b1;
        bytes_left <= size - SW'(dtsfs_pkg::HDR_LEN);
        fill       <= '0;
        commit     <= wr + 1'b1;
        win_start  <= wr + 1'b1;
      end else if (drop) begin
        win_start <= win_start + 1'b1;
      end else begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/dtsfs_cmdq.sv]
// ----------------------------------------------------------------------------
// dtsfs_cmdq
// Short queue of frame requests between the front and the back end.
// ----------------------------------------------------------------------------
module dtsfs_cmdq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dtsfs_pkg::cmd_t din,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output dtsfs_pkg::cmd_t dout
);

  localparam int QW = $clog2(dtsfs_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(dtsfs_pkg::CMDQ_DEPTH + 1);

  dtsfs_pkg::cmd_t entry [dtsfs_pkg::CMDQ_DEPTH];
  logic [QW-1:0]   wp;
  logic [QW-1:0]   rp;
  logic [CW-1:0]   cnt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt == CW'(dtsfs_pkg::CMDQ_DEPTH));
  assign valid   = (cnt != '0);
  assign dout    = entry[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

[hw/rtl/dtsfs_back.sv]
// ----------------------------------------------------------------------------
// dtsfs_back
// Output side: walks the ring for each requested frame, marks first and
// last bytes and buffers results in a small output queue.
// ----------------------------------------------------------------------------
module dtsfs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  dtsfs_pkg::cmd_t               cmd,
  output logic                          cmd_pop,
  input  dtsfs_pkg::ptr_t               commit,
  output logic [dtsfs_pkg::RING_AW-1:0] ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output dtsfs_pkg::back_stat_t         back_stat,
  input  logic                          pop,
  output logic                          empty,
  output dtsfs_pkg::result_t            result
);

  localparam int OW = $clog2(dtsfs_pkg::OUT_DEPTH);
  localparam int CW = $clog2(dtsfs_pkg::OUT_DEPTH + 1);
  localparam int SW = dtsfs_pkg::SIZE_W;

  logic               active;
  dtsfs_pkg::ptr_t    rd;
  dtsfs_pkg::size_t   rem;
  dtsfs_pkg::kind_t   kind;

  logic               infl;
  logic               infl_first;
  logic               infl_last;
  dtsfs_pkg::kind_t   infl_kind;

  dtsfs_pkg::result_t fifo [dtsfs_pkg::OUT_DEPTH];
  logic [OW-1:0]      wp;
  logic [OW-1:0]      rp;
  logic [CW-1:0]      cnt;

  dtsfs_pkg::ptr_t    cur_rd;
  dtsfs_pkg::size_t   cur_rem;
  dtsfs_pkg::kind_t   cur_kind;
  logic               have;
  logic               credit;
  logic               issue;
  logic               do_pop;
  dtsfs_pkg::result_t push_item;

  assign cur_rd   = active ? rd : cmd.start;
  assign cur_rem  = active ? rem : cmd.size;
  assign cur_kind = active ? kind : cmd.kind;
  assign have     = active || cmd_valid;
  // count the read in flight so the queue never overflows
  assign credit   = (cnt + CW'(infl)) < CW'(dtsfs_pkg::OUT_DEPTH);
  assign issue    = have && (cur_rd != commit) && credit;
  assign cmd_pop  = issue && !active;

  assign ram_raddr      = cur_rd[dtsfs_pkg::RING_AW-1:0];
  assign back_stat.busy = have;
  assign back_stat.rd   = cur_rd;

  assign empty  = (cnt == '0);
  assign result = fifo[rp];
  assign do_pop = pop && !empty;

  assign push_item.data  = ram_rdata;
  assign push_item.first = infl_first;
  assign push_item.last  = infl_last;
  assign push_item.kind  = infl_kind;

  always_ff @(posedge clk) begin
    if (issue) begin
      infl_first <= !active;
      infl_last  <= (cur_rem == SW'(1));
      infl_kind  <= cur_kind;
    end
    if (infl) begin
      fifo[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd     <= '0;
      rem    <= '0;
      kind   <= dtsfs_pkg::KIND_16BE;
      infl   <= 1'b0;
      wp     <= '0;
      rp     <= '0;
      cnt    <= '0;
    end else begin
      infl <= issue;
      if (issue) begin
        rd     <= cur_rd + 1'b1;
        rem    <= cur_rem - 1'b1;
        kind   <= cur_kind;
        active <= (cur_rem != SW'(1));
      end
      if (infl) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + CW'(infl) - CW'(do_pop);
    end
  end

endmodule

[hw/rtl/dts_core_frame_sync.sv]
// path: once the back end has caught up, an accepted byte is read from the ring through
//   its registered read port into the output queue, which drives the result ports; a
//   frame's 11 header bytes wait for its 11th byte, then body bytes wait behind them
// throughput: unstalled, one byte in and one result out per cycle (one ring read port)
// input stalls (full) only when the 64-byte ring or the 4-deep frame request queue fills
// reset: synchronous rst empties all queues, restarts hunting, sets min_frame_bytes to 96
// ----------------------------------------------------------------------------
// dts_core_frame_sync
// DTS core frame synchronizer: hunts for sync, passes whole frames with marks.
// ----------------------------------------------------------------------------
module dts_core_frame_sync (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        frame_first,
  output logic        frame_last,
  output logic [1:0]  frame_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  dtsfs_pkg::size_t                min_frame_bytes;
  dtsfs_pkg::back_stat_t           back_stat;
  dtsfs_pkg::cmd_t                 cmd_in;
  dtsfs_pkg::cmd_t                 cmd_out;
  dtsfs_pkg::ptr_t                 commit;
  dtsfs_pkg::result_t              result;
  logic                            cmd_push;
  logic                            cmd_full;
  logic                            cmd_pop;
  logic                            cmd_valid;
  logic                            ram_we;
  logic [dtsfs_pkg::RING_AW-1:0]   ram_waddr;
  logic [dtsfs_pkg::RING_AW-1:0]   ram_raddr;
  logic [7:0]                      ram_wdata;
  logic [7:0]                      ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_bytes <= dtsfs_pkg::MIN_FRAME_RESET;
    end else if (cfg_valid) begin
      min_frame_bytes <= cfg_data;
    end
  end

  dtsfs_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .in_byte         (in_byte),
    .full            (full),
    .min_frame_bytes (min_frame_bytes),
    .back_stat       (back_stat),
    .cmd_full        (cmd_full),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in),
    .commit          (commit),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  dtsfs_ram #(
    .WIDTH (8),
    .DEPTH (dtsfs_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dtsfs_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .valid (cmd_valid),
    .dout  (cmd_out)
  );

  dtsfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .commit    (commit),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .back_stat (back_stat),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign out_byte    = result.data;
  assign frame_first = result.first;
  assign frame_last  = result.last;
  assign frame_kind  = result.kind;

endmodule

[hw/rtl/dtsfs_checker.sv]
// ----------------------------------------------------------------------------
// dtsfs_checker
// Port-level checks of frame marking and result queue behavior.
// ----------------------------------------------------------------------------
module dtsfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte,
  input logic        frame_first,
  input logic        frame_last,
  input logic [1:0]  frame_kind
);

  // tracks whether the last taken result left a frame open
  logic       in_frm;
  logic [1:0] kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frm <= 1'b0;
      kind   <= '0;
    end else if (pop && !empty) begin
      in_frm <= !frame_last;
      kind   <= frame_kind;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_first_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(frame_first && frame_last))
    else $error("frame marked first and last on one byte");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (!empty && !in_frm) |-> frame_first)
    else $error("frame does not open with a first mark");

  a_frame_body: assert property (@(posedge clk) disable iff (rst)
    (!empty && in_frm) |-> (!frame_first && frame_kind == kind))
    else $error("frame body byte with first mark or changed kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(frame_kind)))
    else $error("stalled result changed");

endmodule

bind dts_core_frame_sync dtsfs_checker u_chk (.*);
